[design/strided_gather_chunk_planner_core_defines.svh]
// ----------------------------------------------------------------------------
// strided gather chunk planner assertion macros
// shared property wrappers clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef STRIDED_GATHER_CHUNK_PLANNER_CORE_DEFINES_SVH
`define STRIDED_GATHER_CHUNK_PLANNER_CORE_DEFINES_SVH

// same-cycle implication
`define SGCP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SGCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[design/sgcp_pkg.sv]
// ----------------------------------------------------------------------------
// sgcp_pkg
// types and constants shared by the strided gather chunk planner
// ----------------------------------------------------------------------------
`default_nettype none

package sgcp_pkg;

    localparam int W        = 40;
    localparam int IDX_W    = 4;
    localparam int CNT_W    = 5;
    localparam int MUL_STEPS = 40;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_PREPARE = 2'd1;
    localparam logic [1:0] CMD_NEXT    = 2'd2;

    localparam logic [2:0] ST_STORED  = 3'd0;
    localparam logic [2:0] ST_CONTIG  = 3'd1;
    localparam logic [2:0] ST_READY   = 3'd2;
    localparam logic [2:0] ST_CHUNK   = 3'd3;
    localparam logic [2:0] ST_NONE    = 3'd4;
    localparam logic [2:0] ST_OVF     = 3'd5;

    localparam logic [1:0] CFG_ELEM_BYTES = 2'd0;
    localparam logic [1:0] CFG_DIM_COUNT  = 2'd1;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  dim_index;
        logic [31:0] extent;
        logic [39:0] byte_stride;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [39:0] source_offset;
        logic [39:0] dest_offset;
        logic [39:0] chunk_bytes;
        logic        last_chunk;
    } t_out;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic             clear;
        logic             wr;
        logic [IDX_W-1:0] wr_idx;
        logic [CNT_W-1:0] top;
        logic [W-1:0]     ext;
        logic [W-1:0]     str;
    } t_cell_ctl;

endpackage

`default_nettype wire

[design/sgcp_mul.sv]
// ----------------------------------------------------------------------------
// sgcp_mul
// bit-serial 40x40 multiplier, low 40 bits plus a sticky overflow flag
// ----------------------------------------------------------------------------
`default_nettype none

module sgcp_mul import sgcp_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    output logic              o_busy,
    output logic              o_done,
    output logic [W-1:0]      o_prod,
    output logic              o_ovf
);

    logic [W-1:0] r_a, r_b, r_acc;
    logic         r_ovf, r_done;
    logic [5:0]   r_cnt;
    logic [W+1:0] n_sum;

    // msb first: acc = 2*acc + bit*a
    assign n_sum = {1'b0, r_acc, 1'b0} + {2'b00, (r_b[W-1] ? r_a : '0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
            r_ovf  <= 1'b0;
        end else if (i_start) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_acc  <= '0;
            r_ovf  <= 1'b0;
            r_cnt  <= 6'(MUL_STEPS);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == 6'd1);
            if (r_cnt != '0) begin
                r_acc <= n_sum[W-1:0];
                r_ovf <= r_ovf | (n_sum[W+1:W] != 2'b00);
                r_b   <= {r_b[W-2:0], 1'b0};
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_done = r_done;
    assign o_prod = r_acc;
    assign o_ovf  = r_ovf;

endmodule

`default_nettype wire

[design/sgcp_cell.sv]
// ----------------------------------------------------------------------------
// sgcp_cell
// one merged dimension: extent, stride, coordinate and its offset share
// ----------------------------------------------------------------------------
`default_nettype none

module sgcp_cell import sgcp_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [IDX_W-1:0] i_index,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic             i_carry,
    output logic                  o_carry,
    input  wire logic [W-1:0]     i_sum,
    output logic [W-1:0]          o_sum
);

    logic [W-1:0] r_ext, r_str, r_coord, r_off, r_sum;
    logic         r_carry;
    logic         active, wrap;
    logic [W-1:0] inc;

    assign active = ({1'b0, i_index} < i_ctl.top);
    assign inc    = r_coord + W'(1);
    assign wrap   = (inc >= r_ext);

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && (i_ctl.wr_idx == i_index)) begin
            r_ext <= i_ctl.ext;
            r_str <= i_ctl.str;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord <= '0;
            r_off   <= '0;
            r_carry <= 1'b0;
            r_sum   <= '0;
        end else if (i_ctl.clear) begin
            r_coord <= '0;
            r_off   <= '0;
            r_carry <= 1'b0;
            r_sum   <= i_sum;
        end else begin
            // inactive cells just pass the carry toward the outer end
            r_carry <= active ? (i_carry & wrap) : i_carry;
            if (active && i_carry) begin
                if (wrap) begin
                    r_coord <= '0;
                    r_off   <= '0;
                end else begin
                    r_coord <= inc;
                    r_off   <= r_off + r_str;
                end
            end
            r_sum <= i_sum + (active ? r_off : '0);
        end
    end

    assign o_carry = r_carry;
    assign o_sum   = r_sum;

endmodule

`default_nettype wire

[design/strided_gather_chunk_planner_core.sv]
// ----------------------------------------------------------------------------
// strided_gather_chunk_planner_core
// copy planner turning a strided n-dimensional view into dense row-major
// chunks; a sequencer with a serial multiplier plans, a chain of cells steps
// ----------------------------------------------------------------------------
//
//  channel   signals                              direction
//  input     i_valid / o_ready / i_data (t_in)    command in
//  output    o_valid / i_ready / o_data (t_out)   one result per load, prepare or next
//  config    i_cfg_valid / o_cfg_ready / idx,dat  register write
//
//  load and an empty next: written straight to the result register
//  next: result registered, then a settle wait while carry and offset sum ripple
//  prepare: up to 5*MAX_DIMS-1 serial multiplies
//  a new command is taken only once the previous result transfer is done
//  reset is synchronous; the planner comes up with no plan active
// ----------------------------------------------------------------------------
`default_nettype none

`include "strided_gather_chunk_planner_core_defines.svh"

module strided_gather_chunk_planner_core import sgcp_pkg::*; #(
    parameter int MAX_DIMS = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_in        i_data,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_out            o_data,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [4:0] i_cfg_data
);

    localparam int AW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int SET_N = 2 * MAX_DIMS + 2;
    localparam int SW    = $clog2(SET_N + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_C_RD, S_C_MW, S_S_INIT, S_S_RD, S_S_MW, S_S_EW,
        S_M_RD, S_M_PW, S_M_EW, S_G_OFF, S_G_OW, S_G_CW, S_F_BW, S_SETTLE
    } t_state;

    t_state       r_state;
    logic [4:0]   r_eb;
    logic [3:0]   r_dc;
    logic [31:0]  r_ext_tab [MAX_DIMS];
    logic [W-1:0] r_st_tab  [MAX_DIMS];

    logic [CNT_W-1:0] r_n, r_i, r_c, r_count, r_top;
    logic [W-1:0]     r_expv, r_size, r_cur_e, r_cur_s, r_cl, r_off;
    logic [W-1:0]     r_left, r_dest, r_lext;
    logic             r_final, r_row;
    logic             r_step, r_clear, r_wr;
    logic [W-1:0]     r_wr_e, r_wr_s;
    logic [CNT_W-1:0] r_wr_idx;
    logic [SW-1:0]    r_settle;
    logic             r_mul_go;
    logic [W-1:0]     r_mul_a, r_mul_b;
    logic             r_ovalid;
    t_out             r_out;

    logic             mul_busy, mul_done, mul_ovf;
    logic [W-1:0]     mul_prod;
    logic [W-1:0]     eb40, ext_i, st_i;
    logic [W:0]       off_sum;
    logic [W+4:0]     row_prod;
    logic [W-1:0]     cur_chunk;
    logic [CNT_W-1:0] n_clamp;
    logic             in_fire, cur_row;
    t_cell_ctl        cell_ctl;
    logic             w_carry [MAX_DIMS+1];
    logic [W-1:0]     w_sum   [MAX_DIMS+1];

    function automatic t_out mk_status(input logic [2:0] st);
        t_out r;
        r        = '0;
        r.status = st;
        return r;
    endfunction

    assign eb40    = {35'd0, r_eb};
    assign ext_i   = {8'd0, r_ext_tab[r_i[AW-1:0]]};
    assign st_i    = r_st_tab[r_i[AW-1:0]];
    assign off_sum = {1'b0, r_off} + {1'b0, mul_prod};
    assign cur_row = (r_cur_s == eb40);
    assign in_fire = i_valid && o_ready;

    // chunk length follows the element size in force when the chunk is asked for
    assign row_prod  = r_lext * r_eb;
    assign cur_chunk = r_row ? row_prod[W-1:0] : eb40;

    // dimension count 0 acts as 1, above the table depth as the depth
    assign n_clamp = (r_dc == 4'd0) ? CNT_W'(1) :
                     ({1'b0, r_dc} > CNT_W'(MAX_DIMS)) ? CNT_W'(MAX_DIMS) :
                     {1'b0, r_dc};

    assign o_ready     = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid     = r_ovalid;
    assign o_data      = r_out;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eb <= 5'd4;
            r_dc <= 4'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ELEM_BYTES: r_eb <= i_cfg_data;
                CFG_DIM_COUNT:  r_dc <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // dimension tables, undefined until loaded
    always_ff @(posedge i_clk) begin
        if (in_fire && (i_data.command == CMD_LOAD) &&
            ({2'b00, i_data.dim_index} < CNT_W'(MAX_DIMS))) begin
            r_ext_tab[AW'({2'b00, i_data.dim_index})] <= i_data.extent;
            r_st_tab[AW'({2'b00, i_data.dim_index})]  <= i_data.byte_stride;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_left   <= '0;
            r_dest   <= '0;
            r_count  <= '0;
            r_top    <= '0;
            r_row    <= 1'b0;
            r_step   <= 1'b0;
            r_clear  <= 1'b0;
            r_wr     <= 1'b0;
            r_mul_go <= 1'b0;
            r_settle <= '0;
            r_final  <= 1'b0;
        end else begin
            r_step   <= 1'b0;
            r_clear  <= 1'b0;
            r_wr     <= 1'b0;
            r_mul_go <= 1'b0;
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        case (i_data.command)
                            CMD_LOAD: begin
                                r_out    <= mk_status(ST_STORED);
                                r_ovalid <= 1'b1;
                            end
                            CMD_PREPARE: begin
                                r_n     <= n_clamp;
                                r_i     <= n_clamp - CNT_W'(1);
                                r_expv  <= eb40;
                                r_final <= 1'b0;
                                r_state <= S_C_RD;
                            end
                            CMD_NEXT: begin
                                if (r_left == '0 || r_count == '0 ||
                                    r_count > CNT_W'(MAX_DIMS)) begin
                                    r_out    <= mk_status(ST_NONE);
                                    r_ovalid <= 1'b1;
                                end else begin
                                    r_out.status        <= ST_CHUNK;
                                    r_out.source_offset <= w_sum[MAX_DIMS];
                                    r_out.dest_offset   <= r_dest;
                                    r_out.chunk_bytes   <= cur_chunk;
                                    r_out.last_chunk    <= (r_left == W'(1));
                                    r_ovalid <= 1'b1;
                                    r_dest   <= r_dest + cur_chunk;
                                    r_left   <= r_left - W'(1);
                                    r_step   <= 1'b1;
                                    r_settle <= SW'(SET_N);
                                    r_state  <= S_SETTLE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                // contiguity check from the innermost dimension out
                S_C_RD: begin
                    if (st_i != r_expv) begin
                        r_state <= S_S_INIT;
                    end else begin
                        r_mul_a  <= r_expv;
                        r_mul_b  <= ext_i;
                        r_mul_go <= 1'b1;
                        r_state  <= S_C_MW;
                    end
                end
                S_C_MW: begin
                    if (mul_done) begin
                        if (r_i == '0) begin
                            r_out    <= mk_status(ST_CONTIG);
                            r_ovalid <= 1'b1;
                            r_left   <= '0;
                            r_state  <= S_IDLE;
                        end else if (mul_ovf) begin
                            r_state <= S_S_INIT;
                        end else begin
                            r_expv  <= mul_prod;
                            r_i     <= r_i - CNT_W'(1);
                            r_state <= S_C_RD;
                        end
                    end
                end
                // element count and total byte count
                S_S_INIT: begin
                    r_size  <= W'(1);
                    r_i     <= '0;
                    r_state <= S_S_RD;
                end
                S_S_RD: begin
                    r_mul_a  <= r_size;
                    r_mul_b  <= ext_i;
                    r_mul_go <= 1'b1;
                    r_state  <= S_S_MW;
                end
                S_S_MW: begin
                    if (mul_done) begin
                        if (mul_ovf) begin
                            r_out    <= mk_status(ST_OVF);
                            r_ovalid <= 1'b1;
                            r_left   <= '0;
                            r_state  <= S_IDLE;
                        end else begin
                            r_size <= mul_prod;
                            if (r_i == r_n - CNT_W'(1)) begin
                                r_mul_a  <= mul_prod;
                                r_mul_b  <= eb40;
                                r_mul_go <= 1'b1;
                                r_state  <= S_S_EW;
                            end else begin
                                r_i     <= r_i + CNT_W'(1);
                                r_state <= S_S_RD;
                            end
                        end
                    end
                end
                S_S_EW: begin
                    if (mul_done) begin
                        if (mul_ovf) begin
                            r_out    <= mk_status(ST_OVF);
                            r_ovalid <= 1'b1;
                            r_left   <= '0;
                            r_state  <= S_IDLE;
                        end else if (r_size == '0) begin
                            // empty view, plan with no chunks
                            r_out    <= mk_status(ST_READY);
                            r_ovalid <= 1'b1;
                            r_left   <= '0;
                            r_state  <= S_IDLE;
                        end else begin
                            r_cur_e <= {8'd0, r_ext_tab[0]};
                            r_cur_s <= r_st_tab[0];
                            r_c     <= CNT_W'(1);
                            r_cl    <= W'(1);
                            r_off   <= '0;
                            r_i     <= CNT_W'(1);
                            r_final <= (r_n == CNT_W'(1));
                            r_state <= (r_n == CNT_W'(1)) ? S_G_OFF : S_M_RD;
                        end
                    end
                end
                // merge dimensions whose strides nest
                S_M_RD: begin
                    r_mul_a  <= st_i;
                    r_mul_b  <= ext_i;
                    r_mul_go <= 1'b1;
                    r_state  <= S_M_PW;
                end
                S_M_PW: begin
                    if (mul_done) begin
                        if (!mul_ovf && (r_cur_s == mul_prod)) begin
                            r_mul_a  <= r_cur_e;
                            r_mul_b  <= ext_i;
                            r_mul_go <= 1'b1;
                            r_state  <= S_M_EW;
                        end else begin
                            r_state <= S_G_OFF;
                        end
                    end
                end
                S_M_EW: begin
                    if (mul_done) begin
                        r_cur_e <= mul_prod;
                        r_cur_s <= st_i;
                        if (r_i == r_n - CNT_W'(1)) begin
                            r_final <= 1'b1;
                            r_state <= S_G_OFF;
                        end else begin
                            r_i     <= r_i + CNT_W'(1);
                            r_state <= S_M_RD;
                        end
                    end
                end
                // close the open group: largest offset check and cell write
                S_G_OFF: begin
                    r_mul_a  <= r_cur_e - W'(1);
                    r_mul_b  <= r_cur_s;
                    r_mul_go <= 1'b1;
                    r_state  <= S_G_OW;
                end
                S_G_OW: begin
                    if (mul_done) begin
                        if (mul_ovf || off_sum[W]) begin
                            r_out    <= mk_status(ST_OVF);
                            r_ovalid <= 1'b1;
                            r_left   <= '0;
                            r_state  <= S_IDLE;
                        end else begin
                            r_off    <= off_sum[W-1:0];
                            r_wr     <= 1'b1;
                            r_wr_idx <= r_c - CNT_W'(1);
                            r_wr_e   <= r_cur_e;
                            r_wr_s   <= r_cur_s;
                            r_mul_go <= 1'b1;
                            if (r_final) begin
                                r_mul_a <= r_cur_e;
                                r_mul_b <= eb40;
                                r_state <= S_F_BW;
                            end else begin
                                r_mul_a <= r_cl;
                                r_mul_b <= r_cur_e;
                                r_state <= S_G_CW;
                            end
                        end
                    end
                end
                S_G_CW: begin
                    if (mul_done) begin
                        r_cl    <= mul_prod;
                        r_c     <= r_c + CNT_W'(1);
                        r_cur_e <= ext_i;
                        r_cur_s <= st_i;
                        if (r_i == r_n - CNT_W'(1)) begin
                            r_final <= 1'b1;
                            r_state <= S_G_OFF;
                        end else begin
                            r_i     <= r_i + CNT_W'(1);
                            r_state <= S_M_RD;
                        end
                    end
                end
                // whole rows when the innermost stride is one element
                S_F_BW: begin
                    if (mul_done) begin
                        r_row    <= cur_row;
                        r_lext   <= r_cur_e;
                        r_left   <= cur_row ? r_cl : r_size;
                        r_top    <= cur_row ? (r_c - CNT_W'(1)) : r_c;
                        r_count  <= r_c;
                        r_dest   <= '0;
                        r_clear  <= 1'b1;
                        r_out    <= mk_status(ST_READY);
                        r_ovalid <= 1'b1;
                        r_settle <= SW'(SET_N);
                        r_state  <= S_SETTLE;
                    end
                end
                // carry and offset sum ripple through the chain
                S_SETTLE: begin
                    r_settle <= r_settle - SW'(1);
                    if (r_settle == SW'(1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    sgcp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_go),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_busy  (mul_busy),
        .o_done  (mul_done),
        .o_prod  (mul_prod),
        .o_ovf   (mul_ovf)
    );

    always_comb begin
        cell_ctl.clear  = r_clear;
        cell_ctl.wr     = r_wr;
        cell_ctl.wr_idx = r_wr_idx[IDX_W-1:0];
        cell_ctl.top    = r_top;
        cell_ctl.ext    = r_wr_e;
        cell_ctl.str    = r_wr_s;
    end

    // carry enters at the innermost end, offset sum grows from the outermost
    assign w_carry[MAX_DIMS] = r_step;
    assign w_sum[0]          = '0;

    for (genvar k = 0; k < MAX_DIMS; k++) begin : g_cell
        sgcp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(k)),
            .i_ctl   (cell_ctl),
            .i_carry (w_carry[k+1]),
            .o_carry (w_carry[k]),
            .i_sum   (w_sum[k]),
            .o_sum   (w_sum[k+1])
        );
    end

    // outermost wrap only after the final chunk, or with no stepping cells
    `SGCP_ASSERT_NOW(a_outer_wrap, w_carry[0], (r_left == '0) || (r_top == '0), "outer wrap mid plan")
    // a chunk transfer counts the plan down by one
    `SGCP_ASSERT_NEXT(a_count_down, in_fire && (i_data.command == CMD_NEXT) && (r_left != '0) && (r_count != '0), r_left == $past(r_left) - W'(1), "chunk count not stepped")
    // the serial multiplier is never restarted mid product
    `SGCP_ASSERT_NOW(a_mul_idle, r_mul_go, !mul_busy, "multiplier restarted while busy")

endmodule

`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: strided gather chunk planner testbench
// drives load, prepare and next-chunk commands with random pacing, predicts
// most results with a behavioral planner model and compares field by field
// ----------------------------------------------------------------------------
`default_nettype none

module tb import sgcp_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXD = 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam longint unsigned LIM40 = 64'hFF_FFFF_FFFF;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    t_in        i_data;
    logic       o_valid;
    logic       i_ready;
    t_out       o_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [4:0] i_cfg_data;

    strided_gather_chunk_planner_core #(.MAX_DIMS(MAXD)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // planner model state, a private copy of what the block holds
    // ------------------------------------------------------------------
    longint unsigned elem_b;
    longint unsigned dim_cnt;
    longint unsigned ext_tab [MAXD];
    longint unsigned str_tab [MAXD];
    longint unsigned m_ext [MAXD];
    longint unsigned m_str [MAXD];
    longint unsigned m_cnt;
    longint unsigned coord [MAXD];
    longint unsigned dest_run;
    longint unsigned chunks_left;
    bit              row_chunks;

    t_out pending_results[$];
    logic [7:0] loaded_dims;

    int errors;
    int items_sent;
    int results_seen;
    int chunk_results;
    int status_hits [8];
    bit quiet;          // no idling on either side while set
    bit held_off;
    int idle_cycles;

    // multiply with a 40-bit ceiling; returns 0 when the product does not fit
    function automatic bit mul_fits(input longint unsigned a, input longint unsigned b,
                                    output longint unsigned r);
        if (a != 0 && b > LIM40 / a)
            return 1'b0;
        r = a * b;
        return 1'b1;
    endfunction

    function automatic int active_dims();
        if (dim_cnt < 1)
            return 1;
        if (dim_cnt > MAXD)
            return MAXD;
        return int'(dim_cnt);
    endfunction

    // prepare: contiguity check, overflow check, merge nested dims, plan chunks
    function automatic logic [2:0] plan_prepare();
        longint unsigned me [MAXD];
        longint unsigned ms [MAXD];
        longint unsigned size, cap, expv, p, off, t, cl;
        bit ok, contig;
        int n, c;
        n = active_dims();
        size = 1;
        expv = elem_b;
        off = 0;
        ok = 1'b1;
        contig = 1'b1;
        for (int i = n - 1; i >= 0; i--) begin
            if (!ok || str_tab[i] != expv) begin
                contig = 1'b0;
                break;
            end
            ok = mul_fits(expv, ext_tab[i], expv);
        end
        if (contig) begin
            chunks_left = 0;
            return ST_CONTIG;
        end
        for (int d = 0; d < n; d++) begin
            if (!mul_fits(size, ext_tab[d], size)) begin
                chunks_left = 0;
                return ST_OVF;
            end
        end
        if (!mul_fits(size, elem_b, cap)) begin
            chunks_left = 0;
            return ST_OVF;
        end
        // empty view: plan with nothing in it
        if (size == 0) begin
            chunks_left = 0;
            return ST_READY;
        end
        me[0] = ext_tab[0];
        ms[0] = str_tab[0];
        c = 1;
        for (int d = 1; d < n; d++) begin
            if (mul_fits(str_tab[d], ext_tab[d], p) && ms[c-1] == p) begin
                me[c-1] = (me[c-1] * ext_tab[d]) & LIM40;
                ms[c-1] = str_tab[d];
            end else begin
                me[c] = ext_tab[d];
                ms[c] = str_tab[d];
                c++;
            end
        end
        // largest source offset must fit too
        for (int d = 0; d < c; d++) begin
            if (!mul_fits(me[d] - 1, ms[d], t)) begin
                chunks_left = 0;
                return ST_OVF;
            end
            off += t;
            if (off > LIM40) begin
                chunks_left = 0;
                return ST_OVF;
            end
        end
        row_chunks = (ms[c-1] == elem_b);
        if (row_chunks) begin
            cl = 1;
            for (int d = 0; d + 1 < c; d++)
                cl = (cl * me[d]) & LIM40;
        end else begin
            cl = size;
        end
        for (int d = 0; d < MAXD; d++) begin
            m_ext[d] = (d < c) ? me[d] : 0;
            m_str[d] = (d < c) ? ms[d] : 0;
            coord[d] = 0;
        end
        m_cnt = c;
        dest_run = 0;
        chunks_left = cl;
        return ST_READY;
    endfunction

    // next: emit current chunk, then advance the coordinate odometer
    function automatic t_out plan_next();
        t_out r;
        longint unsigned src, bytes;
        int top;
        r = '0;
        if (chunks_left == 0 || m_cnt < 1 || m_cnt > MAXD) begin
            r.status = ST_NONE;
            return r;
        end
        top = row_chunks ? int'(m_cnt) - 1 : int'(m_cnt);
        src = 0;
        for (int d = 0; d < top; d++)
            src = (src + coord[d] * m_str[d]) & LIM40;
        bytes = row_chunks ? ((m_ext[m_cnt-1] * elem_b) & LIM40) : elem_b;
        r.status        = ST_CHUNK;
        r.source_offset = src[39:0];
        r.dest_offset   = dest_run[39:0];
        r.chunk_bytes   = bytes[39:0];
        r.last_chunk    = (chunks_left == 1);
        dest_run = (dest_run + bytes) & LIM40;
        chunks_left--;
        for (int k = top - 1; k >= 0; k--) begin
            coord[k] = (coord[k] + 1) & LIM40;
            if (coord[k] < m_ext[k])
                break;
            coord[k] = 0;
        end
        return r;
    endfunction

    // returns 1 when the command produces a result
    function automatic bit plan_step(input t_in it, output t_out r);
        r = '0;
        case (it.command)
            CMD_LOAD: begin
                ext_tab[it.dim_index] = it.extent;
                str_tab[it.dim_index] = it.byte_stride;
                loaded_dims[it.dim_index] = 1'b1;
                r.status = ST_STORED;
                return 1'b1;
            end
            CMD_PREPARE: begin
                r.status = plan_prepare();
                return 1'b1;
            end
            CMD_NEXT: begin
                r = plan_next();
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (errors < 40)
            $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // pacing
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // one command transfer; valid stays high afterwards until the next call
    // decides whether to pause, so it is never dropped and raised in one step
    task automatic send_cmd(input t_in it, input bit typed, input logic [2:0] want_status);
        t_out r;
        bit has;
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        has = plan_step(it, r);
        if (has) begin
            // typed rows carry only a status, every other field is zero
            if (typed) begin
                r = '0;
                r.status = want_status;
            end
            pending_results.push_back(r);
        end
    endtask

    task automatic send_fields(input logic [1:0] cmd, input int idx,
                               input longint unsigned ext, input longint unsigned str);
        t_in it;
        it.command     = cmd;
        it.dim_index   = idx[2:0];
        it.extent      = ext[31:0];
        it.byte_stride = str[39:0];
        send_cmd(it, 1'b0, ST_STORED);
    endtask

    // stop offering and wait for every outstanding result plus settle time
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_ELEM_BYTES)
            elem_b = val;
        else if (idx == CFG_DIM_COUNT)
            dim_cnt = val[3:0];
    endtask

    // ------------------------------------------------------------------
    // result checker and receiver pacing
    // ------------------------------------------------------------------
    initial begin
        int stall;
        t_out want;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                results_seen++;
                status_hits[o_data.status]++;
                if (o_data.status == ST_CHUNK)
                    chunk_results++;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result, status", o_data.status, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_data.status != want.status)
                        report_mismatch("status", o_data.status, want.status);
                    if (o_data.source_offset != want.source_offset)
                        report_mismatch("source_offset", o_data.source_offset,
                                        want.source_offset);
                    if (o_data.dest_offset != want.dest_offset)
                        report_mismatch("dest_offset", o_data.dest_offset, want.dest_offset);
                    if (o_data.chunk_bytes != want.chunk_bytes)
                        report_mismatch("chunk_bytes", o_data.chunk_bytes, want.chunk_bytes);
                    if (o_data.last_chunk != want.last_chunk)
                        report_mismatch("last_chunk", o_data.last_chunk, want.last_chunk);
                end
            end
            // one long hold-off while the sender keeps offering
            if (!held_off && results_seen >= 150) begin
                held_off = 1'b1;
                stall = 400;
            end
            if (stall > 0) begin
                stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                    stall = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 3);
            end
        end
    end

    // watchdog: cycles in which no transfer happens on any channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // directed script, run with reset configuration (4-byte elements, 1 dim)
    // ------------------------------------------------------------------
    typedef struct {
        logic [1:0]  cmd;
        logic [2:0]  idx;
        logic [31:0] ext;
        logic [39:0] str;
        bit          typed;
        logic [2:0]  want;
    } t_script_row;

    localparam int SCRIPT_LEN = 22;
    t_script_row script [SCRIPT_LEN] = '{
        '{CMD_NEXT,    3'd0, 32'd0,        40'd0,            1'b1, ST_NONE},   // no plan yet
        '{CMD_UNUSED,  3'd0, 32'd0,        40'd0,            1'b0, ST_NONE},   // ignored code
        '{CMD_LOAD,    3'd0, 32'd6,        40'd4,            1'b1, ST_STORED},
        '{CMD_PREPARE, 3'd0, 32'd0,        40'd0,            1'b1, ST_CONTIG}, // dense already
        '{CMD_LOAD,    3'd0, 32'd5,        40'd8,            1'b1, ST_STORED},
        '{CMD_PREPARE, 3'd0, 32'd0,        40'd0,            1'b1, ST_READY},
        '{CMD_NEXT,    3'd0, 32'd0,        40'd0,            1'b0, ST_NONE},
        '{CMD_NEXT,    3'd0, 32'd0,        40'd0,            1'b0, ST_NONE},
        '{CMD_LOAD,    3'd5, 32'd3,        40'd12,           1'b1, ST_STORED}, // load mid-plan
        '{CMD_NEXT,    3'd0, 32'd0,        40'd0,            1'b0, ST_NONE},
        '{CMD_NEXT,    3'd0, 32'd0,        40'd0,            1'b0, ST_NONE},
        '{CMD_NEXT,    3'd0, 32'd0,        40'd0,            1'b0, ST_NONE},
        '{CMD_NEXT,    3'd0, 32'd0,        40'd0,            1'b1, ST_NONE},   // past the end
        '{CMD_LOAD,    3'd7, 32'hFFFFFFFF, 40'hFF_FFFF_FFFF, 1'b1, ST_STORED},
        '{CMD_LOAD,    3'd0, 32'hFFFFFFFF, 40'hFF_FFFF_FFFF, 1'b1, ST_STORED},
        '{CMD_PREPARE, 3'd0, 32'd0,        40'd0,            1'b1, ST_OVF},    // offset too big
        '{CMD_NEXT,    3'd0, 32'd0,        40'd0,            1'b1, ST_NONE},
        '{CMD_LOAD,    3'd0, 32'd0,        40'd8,            1'b1, ST_STORED},
        '{CMD_PREPARE, 3'd0, 32'd0,        40'd0,            1'b1, ST_READY},  // empty view
        '{CMD_NEXT,    3'd0, 32'd0,        40'd0,            1'b1, ST_NONE},
        '{CMD_LOAD,    3'd0, 32'd3,        40'd0,            1'b1, ST_STORED}, // zero stride
        '{CMD_PREPARE, 3'd0, 32'd0,        40'd0,            1'b1, ST_READY}
    };

    // ------------------------------------------------------------------
    // random sequences
    // ------------------------------------------------------------------

    // full plan: load every active dim with a chosen layout, prepare, walk chunks
    task automatic run_plan();
        longint unsigned e [MAXD];
        longint unsigned s [MAXD];
        longint unsigned prod, tmp;
        int n, layout, order [MAXD], j, swp, guard;
        n = active_dims();
        prod = 1;
        for (int d = 0; d < MAXD; d++) begin
            e[d] = (prod <= 24) ? $urandom_range(1, 4) : 1;
            if ($urandom_range(0, 19) == 0)
                e[d] = 1;
            prod *= e[d];
        end
        layout = $urandom_range(0, 4);
        s[n-1] = (layout == 2) ? elem_b * $urandom_range(2, 3) : elem_b;
        for (int d = n - 2; d >= 0; d--) begin
            s[d] = s[d+1] * e[d+1];
            // padding may break the nesting at any boundary
            if (layout == 1 && $urandom_range(0, 2) == 0)
                s[d] += elem_b * $urandom_range(1, 3);
        end
        if (layout == 3 && n > 1) begin
            j = $urandom_range(0, n - 2);
            tmp = s[j];
            s[j] = s[n-1];
            s[n-1] = tmp;
        end
        if (layout == 4)
            for (int d = 0; d < n; d++)
                s[d] = elem_b * $urandom_range(0, 20);
        // load in a shuffled order
        for (int d = 0; d < n; d++)
            order[d] = d;
        for (int d = n - 1; d > 0; d--) begin
            j = $urandom_range(0, d);
            swp = order[d];
            order[d] = order[j];
            order[j] = swp;
        end
        for (int d = 0; d < n; d++)
            send_fields(CMD_LOAD, order[d], e[order[d]], s[order[d]]);
        send_fields(CMD_PREPARE, 0, $urandom, {$urandom, $urandom});
        guard = 0;
        while (chunks_left != 0 && guard < 80) begin
            if ($urandom_range(0, 29) == 0)
                send_fields(CMD_LOAD, $urandom_range(0, 7), $urandom_range(1, 4),
                            elem_b * $urandom_range(0, 8));
            else
                send_fields(CMD_NEXT, $urandom_range(0, 7), $urandom, $urandom);
            guard++;
        end
        if ($urandom_range(0, 1) == 0)
            send_fields(CMD_NEXT, 0, 0, 0);
    endtask

    // noise and broken sequences
    task automatic run_noise();
        int n;
        n = active_dims();
        case ($urandom_range(0, 5))
            0: send_fields(CMD_LOAD, $urandom_range(0, 7), $urandom,
                           {$urandom_range(0, 255), $urandom});
            1: send_fields(CMD_UNUSED, $urandom_range(0, 7), $urandom, $urandom);
            2: send_fields(CMD_NEXT, $urandom_range(0, 7), $urandom, $urandom);
            3: begin
                if ((loaded_dims & ((9'd1 << n) - 1)) == ((9'd1 << n) - 1))
                    send_fields(CMD_PREPARE, 0, 0, 0);
                else
                    send_fields(CMD_NEXT, 0, 0, 0);
            end
            default: begin
                // huge extents and strides, mostly ending in overflow
                for (int d = 0; d < n; d++)
                    send_fields(CMD_LOAD, d,
                                ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 3),
                                {$urandom_range(0, 255), $urandom});
                send_fields(CMD_PREPARE, 0, 0, 0);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    localparam int PHASES = 12;
    logic [4:0] eb_choice [PHASES] = '{5'd4, 5'd1, 5'd16, 5'd0, 5'd31, 5'd2,
                                       5'd8, 5'd3, 5'd16, 5'd1, 5'd5, 5'd4};
    logic [4:0] dc_choice [PHASES] = '{5'd2, 5'd8, 5'd3, 5'd1, 5'd15, 5'd0,
                                       5'd4, 5'd8, 5'd6, 5'd16, 5'd5, 5'd7};

    initial begin
        t_in it;
        int phase_start;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        chunk_results = 0;
        quiet = 1'b0;
        held_off = 1'b0;
        idle_cycles = 0;
        loaded_dims = '0;
        foreach (status_hits[k])
            status_hits[k] = 0;
        // reset values of the model
        elem_b = 4;
        dim_cnt = 1;
        m_cnt = 0;
        dest_run = 0;
        chunks_left = 0;
        row_chunks = 1'b0;
        for (int d = 0; d < MAXD; d++) begin
            ext_tab[d] = 0;
            str_tab[d] = 0;
            m_ext[d] = 0;
            m_str[d] = 0;
            coord[d] = 0;
        end
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_data      <= '0;
        i_ready     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_ELEM_BYTES;
        i_cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[k]) begin
            it.command     = script[k].cmd;
            it.dim_index   = script[k].idx;
            it.extent      = script[k].ext;
            it.byte_stride = script[k].str;
            send_cmd(it, script[k].typed, script[k].want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            // sender pause: every result back before the registers change
            drain();
            write_reg(CFG_ELEM_BYTES, (ph == PHASES - 1) ? 5'($urandom_range(0, 31))
                                                         : eb_choice[ph]);
            write_reg(CFG_DIM_COUNT, dc_choice[ph]);
            quiet = (ph % 4 == 2);
            phase_start = items_sent;
            while (items_sent - phase_start < 85) begin
                if ($urandom_range(0, 3) != 0)
                    run_plan();
                else
                    run_noise();
            end
        end
        quiet = 1'b0;
        drain();

        $display("ran %0d commands, %0d results checked, %0d chunks",
                 items_sent, results_seen, chunk_results);
        $display("status counts: stored %0d contiguous %0d ready %0d none %0d overflow %0d",
                 status_hits[ST_STORED], status_hits[ST_CONTIG], status_hits[ST_READY],
                 status_hits[ST_NONE], status_hits[ST_OVF]);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            if (pending_results.size() != 0)
                report_mismatch("results never delivered", pending_results.size(), 0);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+design
design/sgcp_pkg.sv
design/sgcp_mul.sv
design/sgcp_cell.sv
design/strided_gather_chunk_planner_core.sv
test/tb.sv
